### src/clkr_pkg.sv
// Shared types, codes and keyword table for the console line keyword router.
package clkr_pkg;

    // Result kinds on the output stream
    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_LINE = 2'd1,
        KIND_DROP = 2'd2
    } kind_t;

    // Console byte codes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;

    // Keyword table geometry
    localparam int KW_COUNT = 26;
    localparam int KW_IDX_W = 5;
    localparam int WLEN_W   = 5;   // word length counter, word stops at 31 characters

    // Matcher control from the sequencer
    typedef struct packed {
        logic       clr;
        logic       step;
        logic [7:0] ch;
    } kw_ctrl_t;

    // Matcher status back to the sequencer
    typedef struct packed {
        logic matched;
        logic word_full;
    } kw_stat_t;

    // Space, TAB, LF, VT, FF and CR
    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == CH_SP) || (b inside {[8'h09:8'h0D]});
    endfunction

    // Keyword text, right-justified: first character in the highest used byte
    function automatic logic [55:0] kw_text(input logic [KW_IDX_W-1:0] k);
        case (k)
            5'd0:    kw_text = 56'("page");
            5'd1:    kw_text = 56'("meow");
            5'd2:    kw_text = 56'("reboot");
            5'd3:    kw_text = 56'("dfu");
            5'd4:    kw_text = 56'("lua_lf");
            5'd5:    kw_text = 56'("lua_k");
            5'd6:    kw_text = 56'("lua");
            5'd7:    kw_text = 56'("paint");
            5'd8:    kw_text = 56'("display");
            5'd9:    kw_text = 56'("info");
            5'd10:   kw_text = 56'("ls");
            5'd11:   kw_text = 56'("clear");
            5'd12:   kw_text = 56'("history");
            5'd13:   kw_text = 56'("resize");
            5'd14:   kw_text = 56'("help");
            5'd15:   kw_text = 56'("kernel");
            5'd16:   kw_text = 56'("stats");
            5'd17:   kw_text = 56'("date");
            5'd18:   kw_text = 56'("device");
            5'd19:   kw_text = 56'("devmem");
            5'd20:   kw_text = 56'("rem");
            5'd21:   kw_text = 56'("retval");
            5'd22:   kw_text = 56'("shell");
            5'd23:   kw_text = 56'("lpm");
            5'd24:   kw_text = 56'("hpm");
            5'd25:   kw_text = 56'("fps");
            default: kw_text = '0;
        endcase
    endfunction

    // Keyword length in characters
    function automatic logic [2:0] kw_len(input logic [KW_IDX_W-1:0] k);
        case (k)
            5'd0, 5'd1, 5'd9, 5'd14, 5'd17:           kw_len = 3'd4;
            5'd2, 5'd4, 5'd13, 5'd15, 5'd18, 5'd19,
            5'd21:                                    kw_len = 3'd6;
            5'd3, 5'd6, 5'd20, 5'd23, 5'd24, 5'd25:   kw_len = 3'd3;
            5'd5, 5'd7, 5'd11, 5'd16, 5'd22:          kw_len = 3'd5;
            5'd8, 5'd12:                              kw_len = 3'd7;
            5'd10:                                    kw_len = 3'd2;
            default:                                  kw_len = 3'd0;
        endcase
    endfunction

    // Character j of keyword k, zero past its end
    function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] k,
                                           input logic [2:0] j);
        logic [55:0] s;
        logic [2:0]  n;
        logic [2:0]  pos;
        s   = kw_text(k);
        n   = kw_len(k);
        pos = n - 3'd1 - j;
        if (j < n)
            kw_char = s[{pos, 3'b000} +: 8];
        else
            kw_char = CH_NUL;
    endfunction

endpackage

### src/clkr_line_mem.sv
// Line character store: one write port, one registered read port.
module clkr_line_mem #(
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read, holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/clkr_kw_match.sv
// Keyword matcher: narrows a candidate mask one word character per step.
module clkr_kw_match (
    input  logic              clk,
    input  logic              rst_n,
    input  clkr_pkg::kw_ctrl_t ctrl,
    output clkr_pkg::kw_stat_t stat
);

    logic [clkr_pkg::KW_COUNT-1:0] cand_reg;
    logic [clkr_pkg::KW_COUNT-1:0] cand_next;
    logic [clkr_pkg::WLEN_W-1:0]   wlen_reg;
    logic [clkr_pkg::WLEN_W-1:0]   wlen_next;
    logic [clkr_pkg::KW_COUNT-1:0] len_hit;

    // Column compare against every keyword; no keyword reaches position 7
    always_comb
    begin
        cand_next = cand_reg;
        wlen_next = wlen_reg;
        if (ctrl.clr)
        begin
            cand_next = '1;
            wlen_next = '0;
        end
        else if (ctrl.step)
        begin
            for (int k = 0; k < clkr_pkg::KW_COUNT; k++)
            begin
                cand_next[k] = cand_reg[k] && (wlen_reg[4:3] == 2'b00) &&
                    (clkr_pkg::kw_char(clkr_pkg::KW_IDX_W'(k), wlen_reg[2:0]) == ctrl.ch);
            end
            wlen_next = wlen_reg + clkr_pkg::WLEN_W'(1);
        end
    end

    // A surviving candidate matches when its length equals the word length
    always_comb
    begin
        for (int k = 0; k < clkr_pkg::KW_COUNT; k++)
        begin
            len_hit[k] = cand_reg[k] &&
                ({2'b00, clkr_pkg::kw_len(clkr_pkg::KW_IDX_W'(k))} == wlen_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
            wlen_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            wlen_reg <= wlen_next;
        end
    end

    assign stat.matched   = |len_hit;
    assign stat.word_full = (wlen_reg == {clkr_pkg::WLEN_W{1'b1}});

endmodule

### src/console_line_keyword_router.sv
// Console line keyword router: line assembly, keyword routing and output stream.
//
// Usage: console bytes enter on the s_axis channel, one byte per transfer, with
// s_axis_tuser carrying the command queue full flag. Results leave on m_axis:
// echo bytes, routed line bytes and dropped notices; m_axis_tlast marks the
// final result caused by one input byte. A backspace on an empty line gives
// no result at all.
// Timing: one byte at a time. s_axis_tready is high only while the sequencer
// is idle. An ordinary byte is echoed once captured; a backspace is echoed
// as backspace, space, backspace. A line end on a non-empty line first scans
// the line for its first word through the single line store read port, one
// read per byte scanned (leading whitespace plus the word), then streams the
// line, or drops it with a notice if a keyword matched with the queue full.
// One output register parts the two sides: a stalled receiver holds the
// current result, and the sequencer waits before issuing the next one.
// Reset: the line is emptied and the output valid is cleared; the line
// store contents are not cleared.
module console_line_keyword_router #(
    parameter int LINE_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       s_axis_tuser,   // [0] command_queue_full
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] value
    output logic [2:0] m_axis_tuser,   // [1:0] kind, [2] destination
    output logic       m_axis_tlast
);

    localparam int             DEPTH = LINE_BYTES - 1;
    localparam int             LEN_W = $clog2(LINE_BYTES);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_BYTES - 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ECHO  = 9'b000000010,
        S_BS1   = 9'b000000100,
        S_BS2   = 9'b000001000,
        S_RD    = 9'b000010000,
        S_CHK   = 9'b000100000,
        S_ROUTE = 9'b001000000,
        S_SRD   = 9'b010000000,
        S_SEND  = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   p_reg, p_next;
    logic [LEN_W-1:0]   p_inc;
    logic               in_word_reg, in_word_next;
    logic [7:0]         c_reg;
    logic               qf_reg;

    logic               out_valid_reg;
    clkr_pkg::kind_t    out_kind_reg;
    logic [7:0]         out_value_reg;
    logic               out_dest_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               emit;
    clkr_pkg::kind_t    emit_kind;
    logic [7:0]         emit_value;
    logic               emit_dest;
    logic               emit_last;

    logic               wr_en;
    logic               rd_en;
    logic [7:0]         rd_data;
    clkr_pkg::kw_ctrl_t kw_ctrl;
    clkr_pkg::kw_stat_t kw_stat;

    logic               is_bs;
    logic               is_eol;
    logic               sp;
    logic               adv;

    clkr_line_mem #(
        .DEPTH (DEPTH),
        .AW    (LEN_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (len_reg),
        .wr_data (c_reg),
        .rd_en   (rd_en),
        .rd_addr (p_reg),
        .rd_data (rd_data)
    );

    clkr_kw_match u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (kw_ctrl),
        .stat  (kw_stat)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign p_inc         = p_reg + LEN_W'(1);
    assign is_bs         = (c_reg == clkr_pkg::CH_BS) || (c_reg == clkr_pkg::CH_DEL);
    assign is_eol        = (c_reg == clkr_pkg::CH_LF) || (c_reg == clkr_pkg::CH_CR);
    assign sp            = clkr_pkg::is_space(rd_data);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        p_next       = p_reg;
        in_word_next = in_word_reg;
        emit         = 1'b0;
        emit_kind    = clkr_pkg::KIND_ECHO;
        emit_value   = c_reg;
        emit_dest    = 1'b0;
        emit_last    = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        kw_ctrl      = '0;
        adv          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = S_ECHO;
            end

            S_ECHO:
            begin
                if (is_bs)
                begin
                    if (len_reg == '0)
                        state_next = S_IDLE;
                    else if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_value = clkr_pkg::CH_BS;
                        len_next   = len_reg - LEN_W'(1);
                        state_next = S_BS1;
                    end
                end
                else if (out_free)
                begin
                    emit = 1'b1;
                    if (is_eol)
                    begin
                        emit_last = (len_reg == '0);
                        if (len_reg == '0)
                            state_next = S_IDLE;
                        else
                        begin
                            p_next       = '0;
                            in_word_next = 1'b0;
                            kw_ctrl.clr  = 1'b1;
                            state_next   = S_RD;
                        end
                    end
                    else
                    begin
                        emit_last = 1'b1;
                        if (len_reg < CAP)
                        begin
                            wr_en    = 1'b1;
                            len_next = len_reg + LEN_W'(1);
                        end
                        state_next = S_IDLE;
                    end
                end
            end

            S_BS1:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_value = clkr_pkg::CH_SP;
                    state_next = S_BS2;
                end
            end

            S_BS2:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_value = clkr_pkg::CH_BS;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // Word scan: skip leading whitespace, then feed word characters
            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (!in_word_reg && sp)
                    adv = 1'b1;
                else if (!sp && (rd_data != clkr_pkg::CH_NUL) && !kw_stat.word_full)
                begin
                    kw_ctrl.step = 1'b1;
                    kw_ctrl.ch   = rd_data;
                    in_word_next = 1'b1;
                    adv          = 1'b1;
                end
                if (adv && (p_inc != len_reg))
                begin
                    p_next     = p_inc;
                    state_next = S_RD;
                end
                else
                    state_next = S_ROUTE;
            end

            S_ROUTE:
            begin
                if (kw_stat.matched && qf_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_kind  = clkr_pkg::KIND_DROP;
                        emit_value = clkr_pkg::CH_NUL;
                        emit_last  = 1'b1;
                        len_next   = '0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    p_next     = '0;
                    state_next = S_SRD;
                end
            end

            // Line stream
            S_SRD:
            begin
                rd_en      = 1'b1;
                state_next = S_SEND;
            end

            S_SEND:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = clkr_pkg::KIND_LINE;
                    emit_value = rd_data;
                    emit_dest  = !kw_stat.matched;
                    emit_last  = (p_inc == len_reg);
                    if (p_inc == len_reg)
                    begin
                        len_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next     = p_inc;
                        state_next = S_SRD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            p_reg       <= '0;
            in_word_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            p_reg       <= p_next;
            in_word_reg <= in_word_next;
        end
    end

    // Input byte capture on transfer
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            c_reg  <= s_axis_tdata;
            qf_reg <= s_axis_tuser;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg  <= emit_kind;
            out_value_reg <= emit_value;
            out_dest_reg  <= emit_dest;
            out_last_reg  <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = {out_dest_reg, out_kind_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
